/* design/telemetry_frame_serializer_top_assert.svh */
// Assertion macros shared by the telemetry frame serializer modules.
`ifndef TELEMETRY_FRAME_SERIALIZER_TOP_ASSERT_SVH
`define TELEMETRY_FRAME_SERIALIZER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define TFS_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`define TFS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define TFS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define TFS_ASSERT_ALWAYS(label, clk, rst_n, cond, msg)
`define TFS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define TFS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

/* design/tfs_pkg.sv */
// Types, constants and helper functions of the telemetry frame serializer.
package tfs_pkg;

    localparam int TFS_CHANNELS_PER_BANK = 8;
    localparam int CHAN_W                = 3;
    localparam int APB_ADDR_W            = 3;
    localparam int APB_DATA_W            = 32;

    localparam logic [15:0] SYNC_RESET    = 16'h6B90;
    localparam logic [15:0] VERSION_RESET = 16'h0063;
    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [15:0] CRC_POLY      = 16'h1021;
    localparam logic [15:0] SAMPLE_RESET  = 16'hBBBB;

    localparam logic [0:0] REG_SYNC    = 1'b0;
    localparam logic [0:0] REG_VERSION = 1'b1;

    localparam logic KIND_STORE = 1'b0;
    localparam logic KIND_TX    = 1'b1;

    localparam logic [3:0] POS_SYNC_HI     = 4'd0;
    localparam logic [3:0] POS_SYNC_LO     = 4'd1;
    localparam logic [3:0] POS_SUBFRAME    = 4'd2;
    localparam logic [3:0] POS_FIXED_FIRST = 4'd3;
    localparam logic [3:0] POS_FIXED_LAST  = 4'd12;
    localparam logic [3:0] POS_SUBCOMM     = 4'd13;
    localparam logic [3:0] POS_CRC_HI      = 4'd14;
    localparam logic [3:0] POS_CRC_LO      = 4'd15;

    localparam logic [3:0] VERSION_SLOT = 4'd11;

    typedef struct packed {
        logic              kind;
        logic              bank;
        logic [CHAN_W-1:0] channel;
        logic [15:0]       sample_value;
    } item_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       frame_last;
    } result_t;

    typedef struct packed {
        logic              bank;
        logic [CHAN_W-1:0] chan;
    } src_t;

    function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    function automatic src_t fixed_src(input logic [2:0] pair);
        src_t s;
        case (pair)
            3'd0:    s = '{bank: 1'b0, chan: 3'd2};
            3'd1:    s = '{bank: 1'b1, chan: 3'd2};
            3'd2:    s = '{bank: 1'b0, chan: 3'd4};
            3'd3:    s = '{bank: 1'b1, chan: 3'd6};
            3'd4:    s = '{bank: 1'b0, chan: 3'd6};
            default: s = '{bank: 1'b0, chan: 3'd2};
        endcase
        return s;
    endfunction

    function automatic src_t sub_src(input logic [3:0] slot);
        src_t s;
        case (slot)
            4'd0:    s = '{bank: 1'b0, chan: 3'd3};
            4'd1:    s = '{bank: 1'b1, chan: 3'd3};
            4'd2:    s = '{bank: 1'b0, chan: 3'd5};
            4'd3:    s = '{bank: 1'b1, chan: 3'd7};
            4'd4:    s = '{bank: 1'b0, chan: 3'd7};
            4'd5:    s = '{bank: 1'b0, chan: 3'd0};
            4'd6:    s = '{bank: 1'b0, chan: 3'd1};
            4'd7:    s = '{bank: 1'b1, chan: 3'd0};
            4'd8:    s = '{bank: 1'b1, chan: 3'd1};
            4'd9:    s = '{bank: 1'b1, chan: 3'd4};
            4'd10:   s = '{bank: 1'b1, chan: 3'd5};
            default: s = '{bank: 1'b0, chan: 3'd3};
        endcase
        return s;
    endfunction

endpackage

/* design/tfs_frame_engine.sv */
// Frame sequencer, sample store and running CRC of the telemetry frame serializer.
`include "telemetry_frame_serializer_top_assert.svh"

module tfs_frame_engine
    import tfs_pkg::*;
#(
    parameter int CHANNELS_PER_BANK = TFS_CHANNELS_PER_BANK
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        fire,
    input  item_t       item,
    input  logic [15:0] sync_word,
    input  logic [15:0] version_word,
    output result_t     result
);

    localparam int DEPTH = 2 * CHANNELS_PER_BANK;
    localparam int IDX_W = $clog2(DEPTH);

    logic [3:0]  frame_pos_reg;
    logic [3:0]  frame_pos_next;
    logic [3:0]  subcomm_slot_reg;
    logic [3:0]  subcomm_slot_next;
    logic        subcomm_phase_reg;
    logic        subcomm_phase_next;
    logic [3:0]  subframe_id_reg;
    logic [3:0]  subframe_id_next;
    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic [7:0]  latched_low_reg;
    logic [7:0]  latched_low_next;
    logic [15:0] store_reg [DEPTH];

    logic             tx_fire;
    logic             store_fire;
    logic [3:0]       fixed_off;
    src_t             rd_src;
    logic [IDX_W-1:0] rd_idx;
    logic [IDX_W-1:0] wr_idx;
    logic [15:0]      rd_word;
    logic [7:0]       byte_out;
    logic             last_out;
    logic             crc_update;

    assign tx_fire    = fire && (item.kind == KIND_TX);
    assign store_fire = fire && (item.kind == KIND_STORE);
    assign fixed_off  = frame_pos_reg - POS_FIXED_FIRST;

    assign rd_src  = (frame_pos_reg == POS_SUBCOMM) ? sub_src(subcomm_slot_reg)
                                                    : fixed_src(fixed_off[3:1]);
    assign rd_idx  = IDX_W'(rd_src.bank) * IDX_W'(CHANNELS_PER_BANK) + IDX_W'(rd_src.chan);
    assign wr_idx  = IDX_W'(item.bank) * IDX_W'(CHANNELS_PER_BANK) + IDX_W'(item.channel);
    assign rd_word = store_reg[rd_idx];

    always_comb
    begin
        frame_pos_next     = frame_pos_reg;
        subcomm_slot_next  = subcomm_slot_reg;
        subcomm_phase_next = subcomm_phase_reg;
        subframe_id_next   = subframe_id_reg;
        latched_low_next   = latched_low_reg;
        byte_out           = 8'h00;
        last_out           = 1'b0;
        crc_update         = 1'b0;
        case (frame_pos_reg) inside
            POS_SYNC_HI:
            begin
                byte_out       = sync_word[15:8];
                frame_pos_next = POS_SYNC_LO;
            end
            POS_SYNC_LO:
            begin
                byte_out       = sync_word[7:0];
                frame_pos_next = POS_SUBFRAME;
            end
            POS_SUBFRAME:
            begin
                byte_out       = {4'h0, subframe_id_reg};
                crc_update     = 1'b1;
                frame_pos_next = POS_FIXED_FIRST;
            end
            [POS_FIXED_FIRST:POS_FIXED_LAST]:
            begin
                if (fixed_off[0] == 1'b0)
                begin
                    byte_out         = rd_word[15:8];
                    latched_low_next = rd_word[7:0];
                end
                else
                begin
                    byte_out = latched_low_reg;
                end
                crc_update     = 1'b1;
                frame_pos_next = frame_pos_reg + 4'd1;
            end
            POS_SUBCOMM:
            begin
                crc_update = 1'b1;
                if (!subcomm_phase_reg)
                begin
                    // Slots past the version slot behave as the version slot.
                    if (subcomm_slot_reg < VERSION_SLOT)
                    begin
                        byte_out         = rd_word[15:8];
                        latched_low_next = rd_word[7:0];
                        subframe_id_next = subframe_id_reg + 4'd1;
                    end
                    else
                    begin
                        byte_out         = version_word[15:8];
                        latched_low_next = version_word[7:0];
                        subframe_id_next = 4'd0;
                    end
                    subcomm_phase_next = 1'b1;
                end
                else
                begin
                    byte_out           = latched_low_reg;
                    subcomm_phase_next = 1'b0;
                    subcomm_slot_next  = (subcomm_slot_reg >= VERSION_SLOT) ? 4'd0
                                                                            : subcomm_slot_reg + 4'd1;
                    frame_pos_next     = POS_CRC_HI;
                end
            end
            POS_CRC_HI:
            begin
                byte_out       = crc_reg[15:8];
                frame_pos_next = POS_CRC_LO;
            end
            POS_CRC_LO:
            begin
                byte_out       = crc_reg[7:0];
                last_out       = 1'b1;
                frame_pos_next = POS_SYNC_HI;
            end
            default:
            begin
                frame_pos_next = POS_SYNC_HI;
            end
        endcase
    end

    always_comb
    begin
        if (last_out)
        begin
            crc_next = CRC_INIT;
        end
        else if (crc_update)
        begin
            crc_next = crc_add(crc_reg, byte_out);
        end
        else
        begin
            crc_next = crc_reg;
        end
    end

    assign result.tx_byte    = byte_out;
    assign result.frame_last = last_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_pos_reg     <= POS_SYNC_HI;
            subcomm_slot_reg  <= 4'd0;
            subcomm_phase_reg <= 1'b0;
            subframe_id_reg   <= 4'd0;
            crc_reg           <= CRC_INIT;
            latched_low_reg   <= 8'h00;
        end
        else if (tx_fire)
        begin
            frame_pos_reg     <= frame_pos_next;
            subcomm_slot_reg  <= subcomm_slot_next;
            subcomm_phase_reg <= subcomm_phase_next;
            subframe_id_reg   <= subframe_id_next;
            crc_reg           <= crc_next;
            latched_low_reg   <= latched_low_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++) begin
                store_reg[i] <= SAMPLE_RESET;
            end
        end
        else if (store_fire)
        begin
            store_reg[wr_idx] <= item.sample_value;
        end
    end

    // Each frame carries the id of the slot it subcommutates.
    `TFS_ASSERT_IMPLIES(a_id_matches_slot, clk, rst_n, frame_pos_reg == POS_SUBFRAME, subframe_id_reg == subcomm_slot_reg, "subframe id differs from subcommutated slot")
    `TFS_ASSERT_IMPLIES(a_phase_in_slot, clk, rst_n, subcomm_phase_reg, frame_pos_reg == POS_SUBCOMM && subcomm_slot_reg <= VERSION_SLOT, "subcommutation phase set outside its slot")
    `TFS_ASSERT_NEXT(a_frame_restart, clk, rst_n, tx_fire && frame_pos_reg == POS_CRC_LO, frame_pos_reg == POS_SYNC_HI && crc_reg == CRC_INIT, "frame did not restart after the CRC")

endmodule

/* design/telemetry_frame_serializer_top.sv */
// Top level of the telemetry frame serializer: handshakes, registers and result stage.
//
//   Channel   Handshake            Payload
//   req       req_valid/req_stall  kind, bank, channel, sample_value
//   tx        tx_valid/tx_stall    tx_byte, frame_last
//   apb       psel/penable/pready  paddr, pwrite, pwdata, prdata
//
// A word is registered on entry and resolved from the entry register, one word per cycle unless it stalls.
// A transmit word enters the result register when it fires from the entry register and shows on tx
// from then on; a store word gives no result.
// The entry stage keeps taking words while a result waits; it stalls only when a
// transmit word finds the result register full and stalled.
// Reset loads every stored sample with 0xBBBB and restarts the frame at its sync bytes.
`include "telemetry_frame_serializer_top_assert.svh"

module telemetry_frame_serializer_top
    import tfs_pkg::*;
#(
    parameter int CHANNELS_PER_BANK = TFS_CHANNELS_PER_BANK
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  logic                  kind,
    input  logic                  bank,
    input  logic [CHAN_W-1:0]     channel,
    input  logic [15:0]           sample_value,
    output logic                  tx_valid,
    input  logic                  tx_stall,
    output logic [7:0]            tx_byte,
    output logic                  frame_last,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [15:0] sync_word_reg;
    logic [15:0] version_word_reg;
    logic        s1_valid_reg;
    logic        s1_valid_next;
    item_t       s1_item_reg;
    logic        tx_valid_reg;
    logic        tx_valid_next;
    result_t     tx_result_reg;

    logic        req_accept;
    logic        s1_is_tx;
    logic        s1_fire;
    logic        apb_write;
    result_t     engine_result;

    assign pready    = 1'b1;
    assign apb_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_word_reg    <= SYNC_RESET;
            version_word_reg <= VERSION_RESET;
        end
        else if (apb_write)
        begin
            case (paddr[2])
                REG_SYNC:    sync_word_reg    <= pwdata[15:0];
                REG_VERSION: version_word_reg <= pwdata[15:0];
                default:     sync_word_reg    <= sync_word_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_SYNC:    prdata = {16'h0000, sync_word_reg};
            REG_VERSION: prdata = {16'h0000, version_word_reg};
            default:     prdata = '0;
        endcase
    end

    assign s1_is_tx   = (s1_item_reg.kind == KIND_TX);
    assign s1_fire    = s1_valid_reg && (!s1_is_tx || !tx_valid_reg || !tx_stall);
    assign req_stall  = s1_valid_reg && !s1_fire;
    assign req_accept = req_valid && !req_stall;

    always_comb
    begin
        if (req_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_comb
    begin
        if (s1_fire && s1_is_tx)
        begin
            tx_valid_next = 1'b1;
        end
        else if (tx_valid_reg && !tx_stall)
        begin
            tx_valid_next = 1'b0;
        end
        else
        begin
            tx_valid_next = tx_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            tx_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            tx_valid_reg <= tx_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            s1_item_reg <= '{kind: kind, bank: bank, channel: channel,
                             sample_value: sample_value};
        end
        if (s1_fire && s1_is_tx)
        begin
            tx_result_reg <= engine_result;
        end
    end

    tfs_frame_engine #(
        .CHANNELS_PER_BANK (CHANNELS_PER_BANK)
    ) u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (s1_fire),
        .item         (s1_item_reg),
        .sync_word    (sync_word_reg),
        .version_word (version_word_reg),
        .result       (engine_result)
    );

    assign tx_valid   = tx_valid_reg;
    assign tx_byte    = tx_result_reg.tx_byte;
    assign frame_last = tx_result_reg.frame_last;

    `TFS_ASSERT_IMPLIES(a_no_overwrite, clk, rst_n, tx_valid_reg && tx_stall, !(s1_fire && s1_is_tx), "result overwritten while stalled")
    `TFS_ASSERT_NEXT(a_result_follows, clk, rst_n, s1_fire && s1_is_tx, tx_valid_reg, "transmit word produced no result")
    `TFS_ASSERT_NEXT(a_stage_holds, clk, rst_n, s1_valid_reg && !s1_fire, s1_valid_reg && $stable(s1_item_reg), "stalled entry stage lost its word")

endmodule

/* dv/tfs_frame_checker.sv */
`timescale 1ns / 1ps
// Frame checker for the telemetry frame serializer: predicts each frame byte and compares it.
module tfs_frame_checker
    import tfs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    input  logic                  req_stall,
    input  logic                  kind,
    input  logic                  bank,
    input  logic [CHAN_W-1:0]     channel,
    input  logic [15:0]           sample_value,
    input  logic                  tx_valid,
    input  logic                  tx_stall,
    input  logic [7:0]            tx_byte,
    input  logic                  frame_last,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output int                    mismatches,
    output int                    bytes_pending,
    output int                    bytes_checked,
    output int                    frames_checked,
    output int                    samples_written
);

    logic [15:0] sync_reg;
    logic [15:0] version_reg;
    logic [3:0]  position;
    logic [3:0]  slot;
    logic        slot_low_next;
    logic [3:0]  subframe;
    logic [15:0] crc;
    logic [7:0]  held_low;
    logic [15:0] samples [16];
    result_t     frame_bytes [$];
    int          mismatch_total;
    int          checked_total;
    int          frame_total;
    int          store_total;

    function automatic logic [15:0] crc_update(input logic [15:0] acc, input logic [7:0] data);
        logic [15:0] r;
        logic        fb;
        r = acc;
        for (int i = 7; i >= 0; i--)
        begin
            fb = r[15] ^ data[i];
            r  = {r[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
        end
        return r;
    endfunction

    function automatic logic [3:0] fixed_entry(input logic [2:0] pair);
        case (pair)
            3'd0:    return 4'd2;
            3'd1:    return 4'd10;
            3'd2:    return 4'd4;
            3'd3:    return 4'd14;
            default: return 4'd6;
        endcase
    endfunction

    function automatic logic [3:0] subcomm_entry(input logic [3:0] s);
        case (s)
            4'd0:    return 4'd3;
            4'd1:    return 4'd11;
            4'd2:    return 4'd5;
            4'd3:    return 4'd15;
            4'd4:    return 4'd7;
            4'd5:    return 4'd0;
            4'd6:    return 4'd1;
            4'd7:    return 4'd8;
            4'd8:    return 4'd9;
            4'd9:    return 4'd12;
            default: return 4'd13;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatch_total < 50)
        begin
            $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        end
        mismatch_total++;
    endtask

    task automatic serialize_next(output result_t r);
        logic [15:0] w;
        logic [3:0]  offset;
        r.tx_byte    = 8'h00;
        r.frame_last = 1'b0;
        if (position == POS_SYNC_HI)
        begin
            r.tx_byte = sync_reg[15:8];
            position  = POS_SYNC_LO;
        end
        else if (position == POS_SYNC_LO)
        begin
            r.tx_byte = sync_reg[7:0];
            position  = POS_SUBFRAME;
        end
        else if (position == POS_SUBFRAME)
        begin
            r.tx_byte = {4'h0, subframe};
            crc       = crc_update(crc, r.tx_byte);
            position  = POS_FIXED_FIRST;
        end
        else if (position <= POS_FIXED_LAST)
        begin
            offset = position - POS_FIXED_FIRST;
            if (!offset[0])
            begin
                w         = samples[fixed_entry(offset[3:1])];
                held_low  = w[7:0];
                r.tx_byte = w[15:8];
            end
            else
            begin
                r.tx_byte = held_low;
            end
            crc      = crc_update(crc, r.tx_byte);
            position = position + 4'd1;
        end
        else if (position == POS_SUBCOMM)
        begin
            if (!slot_low_next)
            begin
                // The version slot also restarts the subframe count.
                if (slot < VERSION_SLOT)
                begin
                    w        = samples[subcomm_entry(slot)];
                    subframe = subframe + 4'd1;
                end
                else
                begin
                    w        = version_reg;
                    subframe = 4'd0;
                end
                held_low      = w[7:0];
                r.tx_byte     = w[15:8];
                slot_low_next = 1'b1;
            end
            else
            begin
                r.tx_byte     = held_low;
                slot_low_next = 1'b0;
                slot          = (slot >= VERSION_SLOT) ? 4'd0 : slot + 4'd1;
                position      = POS_CRC_HI;
            end
            crc = crc_update(crc, r.tx_byte);
        end
        else if (position == POS_CRC_HI)
        begin
            r.tx_byte = crc[15:8];
            position  = POS_CRC_LO;
        end
        else
        begin
            r.tx_byte    = crc[7:0];
            r.frame_last = 1'b1;
            crc          = CRC_INIT;
            position     = POS_SYNC_HI;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t want;
        if (!rst_n)
        begin
            sync_reg      = SYNC_RESET;
            version_reg   = VERSION_RESET;
            position      = POS_SYNC_HI;
            slot          = 4'd0;
            slot_low_next = 1'b0;
            subframe      = 4'd0;
            crc           = CRC_INIT;
            held_low      = 8'h00;
            for (int i = 0; i < 16; i++)
            begin
                samples[i] = SAMPLE_RESET;
            end
            frame_bytes.delete();
            mismatch_total = 0;
            checked_total  = 0;
            frame_total    = 0;
            store_total    = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2:2] == REG_SYNC)
                begin
                    sync_reg = pwdata[15:0];
                end
                else
                begin
                    version_reg = pwdata[15:0];
                end
            end
            if (tx_valid && !tx_stall)
            begin
                if (frame_bytes.size() == 0)
                begin
                    report_mismatch("byte with nothing expected", int'(tx_byte), 0);
                end
                else
                begin
                    want = frame_bytes.pop_front();
                    if (tx_byte !== want.tx_byte)
                    begin
                        report_mismatch("tx_byte", int'(tx_byte), int'(want.tx_byte));
                    end
                    if (frame_last !== want.frame_last)
                    begin
                        report_mismatch("frame_last", int'(frame_last),
                                        int'(want.frame_last));
                    end
                    checked_total++;
                    if (want.frame_last)
                    begin
                        frame_total++;
                    end
                end
            end
            if (req_valid && !req_stall)
            begin
                if (kind == KIND_STORE)
                begin
                    samples[{bank, channel}] = sample_value;
                    store_total++;
                end
                else
                begin
                    serialize_next(want);
                    frame_bytes.push_back(want);
                end
            end
        end
        mismatches      <= mismatch_total;
        bytes_pending   <= frame_bytes.size();
        bytes_checked   <= checked_total;
        frames_checked  <= frame_total;
        samples_written <= store_total;
    end

endmodule

/* dv/telemetry_frame_serializer_top_tb.sv */
`timescale 1ns / 1ps
// Testbench top for the telemetry frame serializer: clock, reset, stimulus and verdict.
module telemetry_frame_serializer_top_tb;
    import tfs_pkg::*;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int HOLD_CYCLES     = 160;
    localparam int WORDS_PER_PHASE = 180;

    logic                  clk;
    logic                  rst_n        = 1'b0;
    logic                  req_valid    = 1'b0;
    logic                  req_stall;
    logic                  kind         = KIND_STORE;
    logic                  bank         = 1'b0;
    logic [CHAN_W-1:0]     channel      = '0;
    logic [15:0]           sample_value = 16'h0000;
    logic                  tx_valid;
    logic                  tx_stall     = 1'b0;
    logic [7:0]            tx_byte;
    logic                  frame_last;
    logic                  psel         = 1'b0;
    logic                  penable      = 1'b0;
    logic                  pwrite       = 1'b0;
    logic [APB_ADDR_W-1:0] paddr        = '0;
    logic [APB_DATA_W-1:0] pwdata       = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int mismatches;
    int bytes_pending;
    int bytes_checked;
    int frames_checked;
    int samples_written;
    int cycle_count;
    int hold_requests = 0;
    int holds_served  = 0;
    int reg_writes    = 0;

    telemetry_frame_serializer_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .kind         (kind),
        .bank         (bank),
        .channel      (channel),
        .sample_value (sample_value),
        .tx_valid     (tx_valid),
        .tx_stall     (tx_stall),
        .tx_byte      (tx_byte),
        .frame_last   (frame_last),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    tfs_frame_checker frame_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (req_valid),
        .req_stall       (req_stall),
        .kind            (kind),
        .bank            (bank),
        .channel         (channel),
        .sample_value    (sample_value),
        .tx_valid        (tx_valid),
        .tx_stall        (tx_stall),
        .tx_byte         (tx_byte),
        .frame_last      (frame_last),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .mismatches      (mismatches),
        .bytes_pending   (bytes_pending),
        .bytes_checked   (bytes_checked),
        .frames_checked  (frames_checked),
        .samples_written (samples_written)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Run stopped after %0d cycles with %0d bytes still outstanding.",
                 cycle_count, bytes_pending);
        $display("telemetry_frame_serializer_top verification failed");
        $finish;
    end

    // The receiver stalls in random modes and serves long hold-off requests from the sender side.
    initial
    begin
        int mode;
        int span;
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(16, 120);
            repeat (span)
            begin
                @(posedge clk);
                if (hold_requests != holds_served)
                begin
                    holds_served++;
                    tx_stall <= 1'b1;
                    repeat (HOLD_CYCLES) @(posedge clk);
                end
                case (mode)
                    0:       tx_stall <= 1'b0;
                    1:       tx_stall <= ($urandom_range(0, 3) == 0);
                    2:       tx_stall <= ($urandom_range(0, 3) != 0);
                    default: tx_stall <= ~tx_stall;
                endcase
            end
        end
    end

    task automatic send_word(input logic k, input logic b, input logic [2:0] ch,
                             input logic [15:0] v);
        req_valid    <= 1'b1;
        kind         <= k;
        bank         <= b;
        channel      <= ch;
        sample_value <= v;
        do @(posedge clk); while (req_stall);
    endtask

    task automatic pause_sender(input int n);
        if (n > 0)
        begin
            req_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic send_random_word();
        logic        k;
        logic [15:0] v;
        k = ($urandom_range(0, 99) < 65) ? KIND_TX : KIND_STORE;
        case ($urandom_range(0, 7))
            0:       v = 16'h0000;
            1:       v = 16'hFFFF;
            default: v = 16'($urandom);
        endcase
        send_word(k, 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), v);
    endtask

    task automatic run_random(input int count, input bit with_hold);
        int burst_left;
        burst_left = 0;
        for (int n = 0; n < count; n++)
        begin
            if (burst_left == 0)
            begin
                pause_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
                burst_left = $urandom_range(1, 24);
            end
            if (with_hold && n == count / 3)
            begin
                hold_requests++;
            end
            send_random_word();
            burst_left--;
        end
    endtask

    task automatic drain(input int tail);
        req_valid <= 1'b0;
        @(posedge clk);
        wait (bytes_pending == 0);
        repeat (tail) @(posedge clk);
    endtask

    task automatic write_register(input logic [0:0] index, input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= {16'h0000, value};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        reg_writes++;
    endtask

    task automatic run_phase(input logic [15:0] sync_value, input logic [15:0] version_value,
                             input bit with_hold);
        drain(4);
        write_register(REG_SYNC, sync_value);
        write_register(REG_VERSION, version_value);
        run_random(WORDS_PER_PHASE, with_hold);
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(KIND_STORE, 1'b0, 3'd0, 16'h0000);
        send_word(KIND_STORE, 1'b1, 3'd7, 16'hFFFF);
        send_word(KIND_STORE, 1'b0, 3'd2, 16'h8001);
        send_word(KIND_STORE, 1'b1, 3'd2, 16'h7FFE);
        send_word(KIND_STORE, 1'b0, 3'd3, 16'hA55A);
        send_word(KIND_TX, 1'b1, 3'd7, 16'hFFFF);
        repeat (16) send_word(KIND_TX, 1'b0, 3'd0, 16'h0000);

        run_random(WORDS_PER_PHASE, 1'b1);
        run_phase(16'h0000, 16'hFFFF, 1'b0);
        run_phase(16'hFFFF, 16'h0000, 1'b0);
        run_phase(16'($urandom), 16'($urandom), 1'b1);
        run_phase(SYNC_RESET, VERSION_RESET, 1'b0);
        drain(8);

        $display("Checked %0d frame bytes across %0d complete frames, with %0d sample writes.",
                 bytes_checked, frames_checked, samples_written);
        $display("Register writes: %0d over five sync/version settings; long receiver holds: %0d.",
                 reg_writes, holds_served);
        if (mismatches == 0)
        begin
            $display("telemetry_frame_serializer_top verification clean");
        end
        else
        begin
            $display("telemetry_frame_serializer_top verification failed");
        end
        $finish;
    end

endmodule
